>>> hw/rtl/ntc_pkg.sv
// Package for the null transition closure block: opcodes, status codes,
// controller states and the command and status structs between the two halves.
// Depends on nothing; imported by every module of the block.
package ntc_pkg;

   localparam int DEF_MAX_STATES = 32;
   localparam int STATE_W        = 5;
   localparam int WEIGHT_W       = 32;
   localparam int STATUS_W       = 3;
   localparam int COUNT_W        = 11;
   localparam int NUM_W          = 6;
   localparam int NUM_RESET      = 32;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_CLOSE,
      OP_QUERY,
      OP_CLEAR
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED,
      ST_UPGRADED,
      ST_UNCHANGED,
      ST_ERROR,
      ST_DONE
   } status_type;

   typedef enum logic [3:0] {
      S_INIT_SWEEP,
      S_IDLE,
      S_ADD_RD,
      S_ADD_WR,
      S_QRY_RD,
      S_QRY_RSP,
      S_CLR_SWEEP,
      S_CL_IK_RD,
      S_CL_IK_LAT,
      S_CL_RD,
      S_CL_UPD,
      S_CL_DONE
   } fsm_type;

   typedef enum logic [1:0] {
      RD_REQ,
      RD_IK,
      RD_KJ
   } rd_sel_type;

   typedef enum logic [1:0] {
      RSP_ADD,
      RSP_QUERY,
      RSP_CLOSE,
      RSP_DONE
   } rsp_kind_type;

   typedef struct packed {
      logic         latch_req;
      logic         sweep_start;
      logic         sweep_step;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         add_write;
      logic         ik_latch;
      logic         cl_start;
      logic         cl_update;
      logic         step_j;
      logic         step_i;
      logic         rsp_en;
      rsp_kind_type rsp_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic ik_skip;
      logic j_last;
      logic ik_final;
   } dp_stat_type;

endpackage

>>> hw/rtl/ntc_ctrl.sv
// Controller state machine of the null transition closure block.
// Depends on ntc_pkg; drives the datapath through ctrl_cmd_type commands.
module ntc_ctrl import ntc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  opcode_type   opcode,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd,
   output logic         busy
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT_SWEEP: begin
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               unique case (opcode)
                  OP_ADD:   state_in = S_ADD_RD;
                  OP_CLOSE: state_in = S_CL_IK_RD;
                  OP_QUERY: state_in = S_QRY_RD;
                  OP_CLEAR: state_in = S_CLR_SWEEP;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_RD:    state_in = S_ADD_WR;
         S_ADD_WR:    state_in = S_IDLE;
         S_QRY_RD:    state_in = S_QRY_RSP;
         S_QRY_RSP:   state_in = S_IDLE;
         S_CLR_SWEEP: begin
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_CL_IK_RD:  state_in = S_CL_IK_LAT;
         S_CL_IK_LAT: begin
            if (!stat.ik_skip) begin
               state_in = S_CL_RD;
            end else if (stat.ik_final) begin
               state_in = S_CL_DONE;
            end else begin
               state_in = S_CL_IK_RD;
            end
         end
         S_CL_RD:     state_in = S_CL_UPD;
         S_CL_UPD: begin
            if (!stat.j_last) begin
               state_in = S_CL_RD;
            end else if (stat.ik_final) begin
               state_in = S_CL_DONE;
            end else begin
               state_in = S_CL_IK_RD;
            end
         end
         S_CL_DONE:   state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_INIT_SWEEP: cmd.sweep_step = 1'b1;
         S_IDLE: begin
            if (start) begin
               cmd.latch_req   = 1'b1;
               cmd.cl_start    = (opcode == OP_CLOSE);
               cmd.sweep_start = (opcode == OP_CLEAR);
            end
         end
         S_ADD_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_REQ;
         end
         S_ADD_WR: begin
            cmd.add_write = 1'b1;
            cmd.rsp_en    = 1'b1;
            cmd.rsp_kind  = RSP_ADD;
         end
         S_QRY_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_REQ;
         end
         S_QRY_RSP: begin
            cmd.rsp_en   = 1'b1;
            cmd.rsp_kind = RSP_QUERY;
         end
         S_CLR_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.rsp_en     = stat.sweep_last;
            cmd.rsp_kind   = RSP_DONE;
         end
         S_CL_IK_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IK;
         end
         S_CL_IK_LAT: begin
            cmd.ik_latch = 1'b1;
            cmd.step_i   = stat.ik_skip && !stat.ik_final;
         end
         S_CL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_KJ;
         end
         S_CL_UPD: begin
            cmd.cl_update = 1'b1;
            cmd.step_j    = !stat.j_last;
            cmd.step_i    = stat.j_last && !stat.ik_final;
         end
         S_CL_DONE: begin
            cmd.rsp_en   = 1'b1;
            cmd.rsp_kind = RSP_CLOSE;
         end
         default: cmd = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> hw/rtl/ntc_datapath.sv
// Datapath of the null transition closure block: transition memory, loop
// counters, the saturating path adder and the result registers.
// Depends on ntc_pkg; steered by ntc_ctrl.
module ntc_datapath import ntc_pkg::*; #(
   parameter int MAX_STATES = DEF_MAX_STATES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_cmd_type               cmd,
   output dp_stat_type                stat,
   input  logic [STATE_W-1:0]         req_src_state,
   input  logic [STATE_W-1:0]         req_dst_state,
   input  logic signed [WEIGHT_W-1:0] req_log_prob,
   input  logic                       csr_write,
   input  logic [NUM_W-1:0]           csr_num_states,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_present,
   output logic signed [WEIGHT_W-1:0] rsp_entry_log_prob,
   output logic [COUNT_W-1:0]         rsp_added_count
);

   localparam int NUM_CELLS = MAX_STATES * MAX_STATES;
   localparam int CELL_W    = $clog2(NUM_CELLS);
   localparam int IDX_W     = $clog2(MAX_STATES);
   localparam int ENTRY_W   = WEIGHT_W + 1;
   localparam int NUM_CAP   = (MAX_STATES > 63) ? 63 : MAX_STATES;

   function automatic logic [CELL_W-1:0] cell_of(input logic [CELL_W-1:0] row,
                                                 input logic [CELL_W-1:0] col);
      cell_of = row * CELL_W'(MAX_STATES) + col;
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] sat_add(
      input logic signed [WEIGHT_W-1:0] a,
      input logic signed [WEIGHT_W-1:0] b);
      logic signed [WEIGHT_W:0] sum;
      sum = {a[WEIGHT_W-1], a} + {b[WEIGHT_W-1], b};
      if (sum[WEIGHT_W] != sum[WEIGHT_W-1]) begin
         sat_add = sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                 : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else begin
         sat_add = sum[WEIGHT_W-1:0];
      end
   endfunction

   logic [ENTRY_W-1:0]         mem [NUM_CELLS];
   logic [ENTRY_W-1:0]         rd_a_ff, rd_b_ff;
   logic [CELL_W-1:0]          rd_addr_a, rd_addr_b, wr_addr;
   logic [ENTRY_W-1:0]         wr_data;
   logic                       wr_en;

   logic [NUM_W-1:0]           num_states_ff;
   logic [STATE_W-1:0]         from_ff, to_ff;
   logic signed [WEIGHT_W-1:0] lp_ff;
   logic [CELL_W-1:0]          sweep_cnt_ff;
   logic [IDX_W-1:0]           i_ff, j_ff, k_ff;
   logic signed [WEIGHT_W-1:0] ik_w_ff;
   logic [COUNT_W-1:0]         count_ff;

   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff, rsp_status_in;
   logic                       rsp_present_ff, rsp_present_in;
   logic signed [WEIGHT_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic [NUM_W-1:0]           n_use;
   logic                       in_range, self_loop, lp_pos, add_err;
   logic [CELL_W-1:0]          req_cell;
   logic                       a_valid, b_valid;
   logic signed [WEIGHT_W-1:0] a_w, b_w, path_w;
   logic                       add_new, add_up, cl_ok, cl_new, cl_up;
   logic                       i_last, k_last;

   assign n_use     = (num_states_ff > NUM_W'(NUM_CAP)) ? NUM_W'(NUM_CAP) : num_states_ff;
   assign in_range  = (NUM_W'(from_ff) < n_use) && (NUM_W'(to_ff) < n_use);
   assign self_loop = (from_ff == to_ff);
   assign lp_pos    = !lp_ff[WEIGHT_W-1] && (lp_ff != '0);
   assign add_err   = lp_pos || !in_range;
   assign req_cell  = in_range ? cell_of(CELL_W'(from_ff), CELL_W'(to_ff)) : '0;

   assign a_valid = rd_a_ff[WEIGHT_W];
   assign a_w     = rd_a_ff[WEIGHT_W-1:0];
   assign b_valid = rd_b_ff[WEIGHT_W];
   assign b_w     = rd_b_ff[WEIGHT_W-1:0];
   assign path_w  = sat_add(ik_w_ff, a_w);

   assign add_new = !add_err && !self_loop && !a_valid;
   assign add_up  = !add_err && !self_loop && a_valid && (a_w < lp_ff);
   assign cl_ok   = (j_ff != i_ff) && (j_ff != k_ff) && a_valid;
   assign cl_new  = cl_ok && !b_valid;
   assign cl_up   = cl_ok && b_valid && (b_w < path_w);

   assign i_last = (i_ff == IDX_W'(MAX_STATES - 1));
   assign k_last = (k_ff == IDX_W'(MAX_STATES - 1));

   assign stat.sweep_last = (sweep_cnt_ff == CELL_W'(NUM_CELLS - 1));
   assign stat.ik_skip    = (i_ff == k_ff) || !a_valid;
   assign stat.j_last     = (j_ff == IDX_W'(MAX_STATES - 1));
   assign stat.ik_final   = i_last && k_last;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_REQ:  rd_addr_a = req_cell;
         RD_IK:   rd_addr_a = cell_of(CELL_W'(i_ff), CELL_W'(k_ff));
         RD_KJ:   rd_addr_a = cell_of(CELL_W'(k_ff), CELL_W'(j_ff));
         default: rd_addr_a = req_cell;
      endcase
   end
   assign rd_addr_b = cell_of(CELL_W'(i_ff), CELL_W'(j_ff));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_cnt_ff;
      wr_data = '0;
      if (cmd.sweep_step) begin
         wr_en = 1'b1;
      end else if (cmd.add_write) begin
         wr_en   = add_new || add_up;
         wr_addr = req_cell;
         wr_data = {1'b1, lp_ff};
      end else if (cmd.cl_update) begin
         wr_en   = cl_new || cl_up;
         wr_addr = rd_addr_b;
         wr_data = {1'b1, path_w};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= NUM_W'(NUM_RESET);
         sweep_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) num_states_ff <= csr_num_states;
         if (cmd.sweep_start) begin
            sweep_cnt_ff <= '0;
         end else if (cmd.sweep_step) begin
            sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         from_ff <= req_src_state;
         to_ff   <= req_dst_state;
         lp_ff   <= req_log_prob;
      end
      if (cmd.ik_latch) ik_w_ff <= a_w;
      if (cmd.cl_start) begin
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.step_j) begin
            j_ff <= j_ff + 1'b1;
         end else if (cmd.step_i) begin
            j_ff <= '0;
            if (i_last) begin
               i_ff <= '0;
               k_ff <= k_ff + 1'b1;
            end else begin
               i_ff <= i_ff + 1'b1;
            end
         end
         if (cmd.cl_update && cl_new && (count_ff != '1)) begin
            count_ff <= count_ff + 1'b1;
         end
      end
      if (cmd.rsp_en) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_present_ff <= rsp_present_in;
         rsp_entry_ff   <= rsp_entry_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   always_comb begin
      rsp_status_in  = ST_DONE;
      rsp_present_in = 1'b0;
      rsp_entry_in   = '0;
      rsp_count_in   = '0;
      case (cmd.rsp_kind)
         RSP_ADD: begin
            if (add_err) begin
               rsp_status_in = ST_ERROR;
            end else if (add_new) begin
               rsp_status_in = ST_ADDED;
            end else if (add_up) begin
               rsp_status_in = ST_UPGRADED;
            end else begin
               rsp_status_in = ST_UNCHANGED;
            end
         end
         RSP_QUERY: begin
            if (!in_range) begin
               rsp_status_in = ST_ERROR;
            end else if (!self_loop && a_valid) begin
               rsp_present_in = 1'b1;
               rsp_entry_in   = a_w;
            end
         end
         RSP_CLOSE: rsp_count_in = count_ff;
         default:   rsp_status_in = ST_DONE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_present        = rsp_present_ff;
   assign rsp_entry_log_prob = rsp_entry_ff;
   assign rsp_added_count    = rsp_count_ff;

endmodule

>>> hw/rtl/null_transition_closure.sv
// Top level of the null transition closure block: controller plus datapath.
// Depends on ntc_pkg, ntc_ctrl and ntc_datapath.
//
//   channel   ports                                          handshake
//   request   req_opcode/src_state/dst_state/log_prob        start & !busy
//   result    rsp_status/present/entry_log_prob/added_count  rsp_valid, one cycle
//   register  csr_num_states                                 csr_valid & csr_ready
//
// Add and query make a registered memory read, then a write or the result; clear
// writes all MAX_STATES*MAX_STATES entries, one entry a cycle through the write port.
// Closure runs over every pivot, row and column, but skips a row with no entry at
// its pivot. After reset a clearing pass over every entry holds busy high.
// Results cannot be stalled; the next item is taken while a result is shown.
module null_transition_closure import ntc_pkg::*; #(
   parameter int MAX_STATES = DEF_MAX_STATES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [STATE_W-1:0]         req_src_state,
   input  logic [STATE_W-1:0]         req_dst_state,
   input  logic signed [WEIGHT_W-1:0] req_log_prob,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_present,
   output logic signed [WEIGHT_W-1:0] rsp_entry_log_prob,
   output logic [COUNT_W-1:0]         rsp_added_count,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [NUM_W-1:0]           csr_num_states
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   ntc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (opcode_type'(req_opcode)),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   ntc_datapath #(
      .MAX_STATES (MAX_STATES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_src_state      (req_src_state),
      .req_dst_state      (req_dst_state),
      .req_log_prob       (req_log_prob),
      .csr_write          (csr_valid && csr_ready),
      .csr_num_states     (csr_num_states),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_present        (rsp_present),
      .rsp_entry_log_prob (rsp_entry_log_prob),
      .rsp_added_count    (rsp_added_count)
   );

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Two results in consecutive cycles.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("An accepted item did not make the block busy.");

   a_count_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_added_count == '0))
      else $error("Creation count on a result other than done.");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ERROR) |-> (!rsp_present && rsp_entry_log_prob == '0))
      else $error("Error result carries entry data.");

endmodule

>>> dv/ntc_closure_checker.sv
// Checker for the null transition closure block: watches the request, result and
// register channels, keeps its own copy of the transition matrix and compares.
// Depends on ntc_pkg for widths, opcodes and status codes.
`timescale 1ns / 100ps
module ntc_closure_checker import ntc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [STATE_W-1:0]         req_src_state,
   input  logic [STATE_W-1:0]         req_dst_state,
   input  logic signed [WEIGHT_W-1:0] req_log_prob,
   input  logic                       rsp_valid,
   input  logic [STATUS_W-1:0]        rsp_status,
   input  logic                       rsp_present,
   input  logic signed [WEIGHT_W-1:0] rsp_entry_log_prob,
   input  logic [COUNT_W-1:0]         rsp_added_count,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [NUM_W-1:0]           csr_num_states,
   output int                         mismatches,
   output int                         outstanding
);

   localparam int N = DEF_MAX_STATES;
   localparam longint W_FLOOR = -(longint'(1) <<< 31);
   localparam longint W_CEIL = (longint'(1) <<< 31) - 1;
   localparam int COUNT_CAP = (1 << COUNT_W) - 1;

   typedef struct {
      status_type                 status;
      logic                       present;
      logic signed [WEIGHT_W-1:0] value;
      logic [COUNT_W-1:0]         count;
   } reply_type;

   bit                         link_valid [N][N];
   logic signed [WEIGHT_W-1:0] link_weight [N][N];
   logic [NUM_W-1:0]           states_reg;
   reply_type                  expected_replies [$];
   int                         mismatch_total = 0;

   assign mismatches = mismatch_total;

   function automatic logic signed [WEIGHT_W-1:0] path_sum(
      input logic signed [WEIGHT_W-1:0] a,
      input logic signed [WEIGHT_W-1:0] b
   );
      longint s;
      s = longint'(a) + longint'(b);
      if (s < W_FLOOR) s = W_FLOOR;
      if (s > W_CEIL) s = W_CEIL;
      return s[WEIGHT_W-1:0];
   endfunction

   // Pivot-ordered sweep; newly created entries take part as pivots further on.
   function automatic int close_matrix();
      int                         created;
      logic signed [WEIGHT_W-1:0] w;
      created = 0;
      for (int k = 0; k < N; k++) begin
         for (int i = 0; i < N; i++) begin
            if (i == k || !link_valid[i][k]) continue;
            for (int j = 0; j < N; j++) begin
               if (j == i || j == k || !link_valid[k][j]) continue;
               w = path_sum(link_weight[i][k], link_weight[k][j]);
               if (!link_valid[i][j]) begin
                  link_valid[i][j] = 1'b1;
                  link_weight[i][j] = w;
                  if (created < COUNT_CAP) created++;
               end else if (link_weight[i][j] < w) begin
                  link_weight[i][j] = w;
               end
            end
         end
      end
      return created;
   endfunction

   function automatic reply_type apply_request(
      input opcode_type                 op,
      input logic [STATE_W-1:0]         src,
      input logic [STATE_W-1:0]         dst,
      input logic signed [WEIGHT_W-1:0] lp
   );
      reply_type   r;
      int unsigned n;
      bit          in_range;
      r.status = ST_DONE;
      r.present = 1'b0;
      r.value = '0;
      r.count = '0;
      n = (int'(states_reg) > N) ? N : int'(states_reg);
      in_range = (src < n) && (dst < n);
      case (op)
         OP_ADD: begin
            // A positive weight is refused before the range and self-loop tests.
            if (lp > 0 || !in_range) begin
               r.status = ST_ERROR;
            end else if (src == dst) begin
               r.status = ST_UNCHANGED;
            end else if (link_valid[src][dst]) begin
               if (link_weight[src][dst] < lp) begin
                  link_weight[src][dst] = lp;
                  r.status = ST_UPGRADED;
               end else begin
                  r.status = ST_UNCHANGED;
               end
            end else begin
               link_valid[src][dst] = 1'b1;
               link_weight[src][dst] = lp;
               r.status = ST_ADDED;
            end
         end
         OP_CLOSE: begin
            r.count = COUNT_W'(close_matrix());
         end
         OP_QUERY: begin
            if (!in_range) begin
               r.status = ST_ERROR;
            end else if (src != dst && link_valid[src][dst]) begin
               r.present = 1'b1;
               r.value = link_weight[src][dst];
            end
         end
         default: begin
            foreach (link_valid[i, j]) link_valid[i][j] = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(
      input string                      what,
      input logic signed [WEIGHT_W-1:0] want,
      input logic signed [WEIGHT_W-1:0] got
   );
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         mismatch_total++;
      end
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         foreach (link_valid[i, j]) link_valid[i][j] = 1'b0;
         states_reg = NUM_W'(NUM_RESET);
         expected_replies.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: result expected none, got status %0d", $time, rsp_status);
               mismatch_total++;
            end else begin
               want = expected_replies.pop_front();
               check_field("status", WEIGHT_W'(want.status), WEIGHT_W'(rsp_status));
               check_field("present", WEIGHT_W'(want.present), WEIGHT_W'(rsp_present));
               check_field("entry_log_prob", want.value, rsp_entry_log_prob);
               check_field("added_count", WEIGHT_W'(want.count),
                           WEIGHT_W'(rsp_added_count));
            end
         end
         if (csr_valid && csr_ready) states_reg = csr_num_states;
         if (start && !busy) begin
            expected_replies.push_back(apply_request(opcode_type'(req_opcode),
               req_src_state, req_dst_state, req_log_prob));
         end
         outstanding <= expected_replies.size();
      end
   end

endmodule

>>> dv/tb_null_transition_closure.sv
// Testbench top for the null transition closure block: clock, reset, directed and
// random requests, register writes and the final verdict.
// Depends on ntc_pkg, null_transition_closure and ntc_closure_checker.
`timescale 1ns / 100ps
module tb_null_transition_closure import ntc_pkg::*; ();

   localparam int ITEM_TARGET = 1950;
   localparam int STALL_LIMIT = 250000;
   localparam int DRAIN_CYCLES = 20;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_opcode = '0;
   logic [STATE_W-1:0]         req_src_state = '0;
   logic [STATE_W-1:0]         req_dst_state = '0;
   logic signed [WEIGHT_W-1:0] req_log_prob = '0;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_present;
   logic signed [WEIGHT_W-1:0] rsp_entry_log_prob;
   logic [COUNT_W-1:0]         rsp_added_count;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [NUM_W-1:0]           csr_num_states = '0;
   int                         mismatches;
   int                         outstanding;
   int                         idle_cycles = 0;
   int                         items_sent = 0;
   int unsigned                gap_cap = 3;
   bit                         matrix_dense = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   null_transition_closure dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_src_state      (req_src_state),
      .req_dst_state      (req_dst_state),
      .req_log_prob       (req_log_prob),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_present        (rsp_present),
      .rsp_entry_log_prob (rsp_entry_log_prob),
      .rsp_added_count    (rsp_added_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_num_states     (csr_num_states)
   );

   ntc_closure_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_src_state      (req_src_state),
      .req_dst_state      (req_dst_state),
      .req_log_prob       (req_log_prob),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_present        (rsp_present),
      .rsp_entry_log_prob (rsp_entry_log_prob),
      .rsp_added_count    (rsp_added_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_num_states     (csr_num_states),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Start stays high from one item to the next when no gap is drawn.
   task automatic issue(
      input opcode_type                 op,
      input logic [STATE_W-1:0]         src,
      input logic [STATE_W-1:0]         dst,
      input logic signed [WEIGHT_W-1:0] lp
   );
      int unsigned gap;
      gap = $urandom_range(0, gap_cap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_src_state <= src;
      req_dst_state <= dst;
      req_log_prob <= lp;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic set_num_states(input int unsigned value);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_valid <= 1'b1;
      csr_num_states <= value[NUM_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return -1;
         2: return -int'($urandom_range(0, 1000));
         3: return 32'sh8000_0000 + int'($urandom_range(0, 1000));
         4: return {1'b1, 31'($urandom)};
         default: return -int'($urandom_range(0, 1 << 20));
      endcase
   endfunction

   function automatic logic [STATE_W-1:0] any_state();
      return STATE_W'($urandom_range(0, DEF_MAX_STATES - 1));
   endfunction

   function automatic logic [STATE_W-1:0] pick_state(input int unsigned n);
      if (n == 0 || n == DEF_MAX_STATES) return any_state();
      if ($urandom_range(0, 9) == 0) return STATE_W'($urandom_range(n, DEF_MAX_STATES - 1));
      return STATE_W'($urandom_range(0, n - 1));
   endfunction

   // One run of the matrix: an optional clear, a new state count, a burst of adds
   // and queries with some noise, then a closure and a few queries of its result.
   // Large state counts get short bursts so that the closure stays cheap.
   task automatic run_episode();
      int unsigned        reg_value;
      int unsigned        n;
      int unsigned        len;
      int unsigned        p;
      bit                 big;
      opcode_type         op;
      logic [STATE_W-1:0] src;
      logic [STATE_W-1:0] dst;
      logic [STATE_W-1:0] last_src;
      logic [STATE_W-1:0] last_dst;
      if (matrix_dense || $urandom_range(0, 1) == 1) begin
         issue(OP_CLEAR, any_state(), any_state(), $urandom);
      end
      case ($urandom_range(0, 19))
         0: reg_value = 0;
         1: reg_value = 1;
         2: reg_value = DEF_MAX_STATES;
         3: reg_value = $urandom_range(DEF_MAX_STATES + 1, (1 << NUM_W) - 1);
         4, 5: reg_value = $urandom_range(9, DEF_MAX_STATES - 1);
         default: reg_value = $urandom_range(2, 8);
      endcase
      set_num_states(reg_value);
      n = (reg_value > DEF_MAX_STATES) ? DEF_MAX_STATES : reg_value;
      big = (n > 8);
      matrix_dense = big;
      gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 3;
      len = big ? $urandom_range(8, 16) : $urandom_range(10, 40);
      last_src = '0;
      last_dst = STATE_W'(1);
      repeat (len) begin
         p = $urandom_range(0, 99);
         if (p < 60) begin
            src = pick_state(n);
            dst = ($urandom_range(0, 11) == 0) ? src : pick_state(n);
            issue(OP_ADD, src, dst, pick_weight());
            last_src = src;
            last_dst = dst;
         end else if (p < 78) begin
            issue(OP_QUERY, pick_state(n), pick_state(n), $urandom);
         end else if (p < 86) begin
            issue(OP_ADD, last_src, last_dst, pick_weight());
         end else if (p < 96) begin
            op = opcode_type'($urandom_range(0, 3));
            if (op == OP_CLOSE && big) op = OP_QUERY;
            issue(op, any_state(), any_state(), $urandom);
         end else if (!big) begin
            issue(OP_CLOSE, any_state(), any_state(), $urandom);
         end else begin
            issue(OP_QUERY, last_src, last_dst, $urandom);
         end
      end
      issue(OP_CLOSE, any_state(), any_state(), $urandom);
      repeat ($urandom_range(2, 6)) issue(OP_QUERY, pick_state(n), pick_state(n), $urandom);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      issue(OP_QUERY, 5'd0, 5'd1, 32'sd0);
      issue(OP_ADD, 5'd0, 5'd1, 32'sd0);
      issue(OP_ADD, 5'd0, 5'd1, -32'sd5);
      issue(OP_ADD, 5'd0, 5'd1, 32'sd1);
      issue(OP_ADD, 5'd31, 5'd31, 32'sh7fff_ffff);
      issue(OP_ADD, 5'd3, 5'd3, -32'sd9);
      issue(OP_ADD, 5'd1, 5'd2, 32'sh8000_0000);
      issue(OP_ADD, 5'd1, 5'd2, -32'sd100);
      issue(OP_ADD, 5'd2, 5'd4, 32'sh8000_0000);
      issue(OP_ADD, 5'd31, 5'd0, -32'sd7);
      issue(OP_QUERY, 5'd3, 5'd3, 32'sd0);
      issue(OP_CLOSE, 5'd0, 5'd0, 32'sd0);
      issue(OP_QUERY, 5'd1, 5'd4, 32'sd0);
      issue(OP_QUERY, 5'd31, 5'd4, 32'sd0);
      set_num_states(0);
      issue(OP_ADD, 5'd0, 5'd1, 32'sd0);
      issue(OP_QUERY, 5'd0, 5'd1, 32'sd0);
      issue(OP_CLOSE, 5'd0, 5'd0, 32'sd0);
      set_num_states((1 << NUM_W) - 1);
      issue(OP_ADD, 5'd31, 5'd30, -32'sd3);
      issue(OP_QUERY, 5'd31, 5'd30, 32'sd0);
      set_num_states(1);
      issue(OP_ADD, 5'd0, 5'd0, 32'sd0);
      issue(OP_QUERY, 5'd0, 5'd0, 32'sd0);
      issue(OP_ADD, 5'd0, 5'd1, -32'sd1);
      issue(OP_CLEAR, 5'd31, 5'd31, -32'sd1);
      matrix_dense = 1'b0;

      while (items_sent < ITEM_TARGET) run_episode();

      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_ctrl.sv
hw/rtl/ntc_datapath.sv
hw/rtl/null_transition_closure.sv
dv/ntc_closure_checker.sv
dv/tb_null_transition_closure.sv
